/* hw/rtl/swrt_pkg.sv */
// Shared constants, codes and types of the sliding-window rate trigger.
package swrt_pkg;

   // Ring depth of stored hit stamps
   localparam int WINDOW_DEPTH = 16;

   localparam int HEAD_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int COUNT_W = 5;
   localparam int CNT_W   = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
   localparam int STAMP_W = 32;
   localparam int WIN_W   = 16;
   localparam int OP_W    = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd60;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 5'd1;

   typedef enum logic [OP_W-1:0] {
      OP_HIT   = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WINDOW  = 2'd0,
      CSR_COUNT   = 2'd1,
      CSR_AT_MOST = 2'd2,
      CSR_PERSIST = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WIN_W-1:0]   window_seconds;
      logic [COUNT_W-1:0] hit_threshold;
      logic               at_most_mode;
      logic               persistent_mode;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic push;
      logic pop_one;
      logic trim;
      logic finish_hit;
      logic finish_other;
      logic finish_keep;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic keep;
      logic expired;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/swrt_csr.sv */
// Configuration register file of the sliding-window rate trigger.
module swrt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [swrt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [swrt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output swrt_pkg::cfg_type               cfg
);

   swrt_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            swrt_pkg::CSR_WINDOW:  cfg_in.window_seconds  = csr_wdata[swrt_pkg::WIN_W-1:0];
            swrt_pkg::CSR_COUNT:   cfg_in.hit_threshold   = csr_wdata[swrt_pkg::COUNT_W-1:0];
            swrt_pkg::CSR_AT_MOST: cfg_in.at_most_mode    = csr_wdata[0];
            swrt_pkg::CSR_PERSIST: cfg_in.persistent_mode = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_seconds  <= swrt_pkg::WINDOW_RESET;
         cfg_ff.hit_threshold   <= swrt_pkg::COUNT_RESET;
         cfg_ff.at_most_mode    <= 1'b0;
         cfg_ff.persistent_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/swrt_ctrl.sv */
// Sequencing state machine of the sliding-window rate trigger.
module swrt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic [swrt_pkg::OP_W-1:0] req_op,
   output logic                      req_tready,
   input  swrt_pkg::sts_type         sts,
   output swrt_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_KEEP,
      S_EXPIRE,
      S_TRIM,
      S_SCHED,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (req_op == swrt_pkg::OP_HIT) ? S_PUSH : S_EXEC;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = sts.keep ? S_KEEP : S_EXPIRE;
         end
         S_KEEP: begin
            if (sts.out_free) begin
               cmd.pop_one     = 1'b1;
               cmd.finish_keep = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_EXPIRE: begin
            // drop stale stamps from the front, one a cycle
            if (sts.expired) begin
               cmd.pop_one = 1'b1;
            end else begin
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            cmd.trim = 1'b1;
            state_in = S_SCHED;
         end
         S_SCHED: begin
            if (sts.out_free) begin
               cmd.finish_hit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               cmd.finish_other = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/swrt_datapath.sv */
// Stamp ring, cell state and result register of the sliding-window rate trigger.
module swrt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  swrt_pkg::cfg_type               cfg,
   input  logic [swrt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [swrt_pkg::OP_W-1:0]       req_tuser,
   input  swrt_pkg::cmd_type               cmd,
   output swrt_pkg::sts_type               sts,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [swrt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DEPTH   = swrt_pkg::WINDOW_DEPTH;
   localparam int HEAD_W  = swrt_pkg::HEAD_W;
   localparam int FILL_W  = swrt_pkg::FILL_W;
   localparam int CNT_W   = swrt_pkg::CNT_W;
   localparam int STAMP_W = swrt_pkg::STAMP_W;

   logic [STAMP_W-1:0] mem [DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;

   logic [STAMP_W-1:0]         stamp_ff;
   logic [swrt_pkg::OP_W-1:0]  op_ff;
   logic [HEAD_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic                       cell_on_ff, cell_on_in;
   logic [STAMP_W-1:0]         deadline_ff, deadline_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [swrt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 we;
   logic [HEAD_W-1:0]    waddr;
   logic [FILL_W:0]      push_sum;
   logic [HEAD_W-1:0]    head_inc;
   logic [CNT_W-1:0]     tc_c, fill_c, trim_diff;
   logic [CNT_W:0]       trim_sum;
   logic [HEAD_W-1:0]    head_trim;
   logic [STAMP_W-1:0]   age;
   logic [STAMP_W-1:0]   window_x;
   logic [STAMP_W-1:0]   deadline_calc;
   logic                 fill_full;
   logic                 count_met;
   logic                 next_on;
   logic                 sched_valid;
   logic [STAMP_W-1:0]   sched_time;
   logic                 finish;

   assign window_x  = STAMP_W'(cfg.window_seconds);
   assign fill_full = (fill_ff == FILL_W'(DEPTH));
   assign head_inc  = (head_ff == HEAD_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // push slot: head plus fill, wrapped
   assign push_sum = (FILL_W + 1)'(head_ff) + (FILL_W + 1)'(fill_ff);
   assign waddr    = fill_full ? head_ff :
                     (push_sum >= (FILL_W + 1)'(DEPTH)) ? HEAD_W'(push_sum - (FILL_W + 1)'(DEPTH))
                                                        : HEAD_W'(push_sum);
   assign we       = cmd.push;

   // zero trigger count counts as one
   assign tc_c      = (cfg.hit_threshold == '0) ? CNT_W'(1) : CNT_W'(cfg.hit_threshold);
   assign fill_c    = CNT_W'(fill_ff);
   assign trim_diff = fill_c - tc_c;
   assign trim_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(trim_diff);
   assign head_trim = (trim_sum >= (CNT_W + 1)'(DEPTH)) ? HEAD_W'(trim_sum - (CNT_W + 1)'(DEPTH))
                                                        : HEAD_W'(trim_sum);

   assign age           = stamp_ff - rd_data_ff;
   assign deadline_calc = rd_data_ff + window_x + STAMP_W'(1);
   assign count_met     = (fill_c == tc_c);
   assign finish        = cmd.finish_hit | cmd.finish_other | cmd.finish_keep;

   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      cell_on_in  = cell_on_ff;
      deadline_in = deadline_ff;
      next_on     = cell_on_ff;
      sched_valid = 1'b0;
      sched_time  = '0;

      if (cmd.push) begin
         if (fill_full) begin
            head_in = head_inc;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.pop_one && fill_ff != '0) begin
         head_in = head_inc;
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.trim && fill_c > tc_c) begin
         head_in = head_trim;
         fill_in = FILL_W'(tc_c);
      end

      if (cmd.finish_hit) begin
         next_on = count_met && !cfg.at_most_mode;
         if (count_met || cfg.at_most_mode) begin
            deadline_in = deadline_calc;
            sched_valid = 1'b1;
            sched_time  = deadline_calc;
         end
      end else if (cmd.finish_other) begin
         case (op_ff)
            swrt_pkg::OP_TICK: begin
               if (stamp_ff == deadline_ff) begin
                  next_on = cfg.at_most_mode || cfg.persistent_mode;
               end
            end
            swrt_pkg::OP_CLEAR: begin
               next_on     = 1'b0;
               deadline_in = '0;
               fill_in     = '0;
               head_in     = '0;
            end
            default: next_on = cell_on_ff;
         endcase
      end
      if (cmd.finish_hit || cmd.finish_other) begin
         cell_on_in = next_on;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(swrt_pkg::RSP_DATA_W - STAMP_W - 3)'(0), sched_time, sched_valid,
                         next_on, next_on != cell_on_ff};
      end
   end

   // ring memory; read the head of the next cycle, forward a same-slot write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we && waddr == head_in) begin
         rd_data_ff <= stamp_ff;
      end else begin
         rd_data_ff <= mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stamp_ff <= req_tdata[STAMP_W-1:0];
         op_ff    <= req_tuser;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         cell_on_ff   <= 1'b0;
         deadline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cell_on_ff   <= cell_on_in;
         deadline_ff  <= deadline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.keep     = cell_on_ff && cfg.persistent_mode;
   assign sts.expired  = (fill_ff != '0) && !age[STAMP_W-1] && (age > window_x);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/sliding_window_rate_trigger.sv */
// Top level of the sliding-window rate trigger: config registers, controller, datapath.
//
// Detects whether at least (or at most) the configured count of hits fell within
// window_seconds, holding up to 16 hit stamps in a ring memory. The block works on one
// beat at a time: a tick, a clear or an unused op passes through the execute state to its
// result, and a hit passes through push, expiry walk, trim and schedule, the walk dropping
// up to 15 stale stamps from the front of the ring, since it reads and tests one stored
// stamp per cycle on the single memory read port; a hit that arrives while the cell is on
// in persistent mode passes through push and keep instead. The next request is taken
// once the result sits in the output register, so a slow result consumer stalls the
// block only when a second result is ready. Every request beat gives exactly one result
// beat. Write configuration only while idle.
module sliding_window_rate_trigger (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swrt_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] stamp_seconds
   input  logic [swrt_pkg::OP_W-1:0]       req_tuser,  // [1:0] op
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] changed, [1] on_state, [2] schedule_valid, [34:3] schedule_time, [39:35] zero
   output logic [swrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                            csr_we,
   input  logic [swrt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [swrt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   swrt_pkg::cfg_type cfg;
   swrt_pkg::cmd_type cmd;
   swrt_pkg::sts_type sts;

   swrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequence push, expiry walk, trim and result per beat
   swrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold the stamp ring, cell state, deadline and output register
   swrt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hw/rtl/swrt_checker.sv */
// Port-level checks of the sliding-window rate trigger, bound to the top level.
module swrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [swrt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   // one request in flight: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // without a schedule the deadline field reads zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[34:3] == 32'd0)
      else $error("schedule_time set without schedule_valid");

endmodule

bind sliding_window_rate_trigger swrt_checker u_swrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
